// ===== rtl/raster_isolated_point_cleanup_defines.svh =====
// Assertion macros for the raster isolated point cleanup RTL.
`ifndef RASTER_ISOLATED_POINT_CLEANUP_DEFINES_SVH
`define RASTER_ISOLATED_POINT_CLEANUP_DEFINES_SVH

`ifndef ASSERT_OFF

`define RPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rpc assertion failed");

`define RPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpc assertion failed");

`else

`define RPC_ASSERT(lbl, clk, rst, prop)
`define RPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/rpc_pkg.sv =====
// Types, codes and constants of the raster isolated point cleanup block.
`default_nettype none

package rpc_pkg;

  localparam int PIX_W     = 24;
  localparam int IN_W      = 16;
  localparam int IDX_W     = 8;
  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int CNT_W     = 4;
  localparam int TAP_W     = 4;
  localparam int DEL_LIMIT = 6;
  localparam int NBR_COUNT = 8;
  localparam int NBR_SH    = $clog2(NBR_COUNT);
  localparam int SUM_W     = PIX_W + NBR_SH;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL = 2'd2;

  localparam logic [DIM_W-1:0]      ROWS_RESET = 9'd256;
  localparam logic [DIM_W-1:0]      COLS_RESET = 9'd256;
  localparam logic signed [IN_W-1:0] FILL_RESET = -16'sd9999;

  localparam logic [TAP_W-1:0] TAP_CENTER = 4'd0;
  localparam logic [TAP_W-1:0] TAP_LAST   = 4'd8;

  typedef logic signed [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [IN_W-1:0]  pixel_in;
  } in_word_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_out;
    logic                    pass_done;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic is_center;
  } nbr_ctl_t;

  typedef struct packed {
    logic update;
    pix_t value;
  } nbr_res_t;

  function automatic pix_t to_fixed(logic signed [IN_W-1:0] v, int unsigned sh);
    logic [31:0] w;
    w = 32'(v);
    w = w << sh;
    return w[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpc_frame_mem.sv =====
// Frame store: one write port and one registered read port.
`default_nettype none

module rpc_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int DW    = 24,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/rpc_nbr_unit.sv =====
// Shared neighborhood unit: classifies one pixel per cycle while ctl.take is set and forms the update.
`default_nettype none

module rpc_nbr_unit
  import rpc_pkg::*;
(
  input  wire logic     clk,
  input  wire nbr_ctl_t ctl,
  input  wire pix_t     data,
  input  wire pix_t     fill_fix,
  output nbr_res_t      res
);

  logic                    center_bad;
  logic [CNT_W-1:0]        bad_cnt;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] adj;
  logic signed [SUM_W-1:0] mean;
  logic                    data_bad;

  assign data_bad = (data == '0) || (data == fill_fix);

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      if (ctl.is_center) begin
        center_bad <= data_bad;
        bad_cnt    <= '0;
        sum        <= '0;
      end else if (data_bad) begin
        bad_cnt <= bad_cnt + CNT_W'(1);
      end else begin
        sum <= sum + SUM_W'(data);
      end
    end
  end

  // The mean truncates toward zero, so negative sums are biased before the shift.
  assign adj  = sum + (sum[SUM_W-1] ? SUM_W'(NBR_COUNT - 1) : SUM_W'(0));
  assign mean = adj >>> NBR_SH;

  always_comb begin
    if (center_bad) begin
      res.update = (bad_cnt == '0);
      res.value  = mean[PIX_W-1:0];
    end else begin
      res.update = (bad_cnt >= CNT_W'(DEL_LIMIT));
      res.value  = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/raster_isolated_point_cleanup.sv =====
// Top level of the raster isolated point cleanup block with its scan sequencer.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   in_word_t
//   rsp      out        rsp_valid/rsp_stall   out_word_t
//   cfg      in         cfg_we                cfg_index, cfg_data
//
// A pixel write goes to the frame store write port; a pixel read goes through the registered read port and S_READ.
// A run visits each interior pixel in turn: nine reads on the single read port, then the
// drain state and the write-back state.
// Reset clears the sequencer and the registers; the frame store is not cleared.
// A word is accepted only in the idle state while the result slot is free or being taken.

`default_nettype none
`include "raster_isolated_point_cleanup_defines.svh"

module raster_isolated_point_cleanup
  import rpc_pkg::*;
#(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire in_word_t             req_word,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output out_word_t                 rsp_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RLIM_W = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;
  localparam int CLIM_W = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
  localparam logic [AW-1:0] A_ONE  = AW'(1);
  localparam logic [AW-1:0] A_COLS = AW'(MAX_COLS);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_FETCH, S_DRAIN, S_WB} state_t;

  state_t                 state;
  logic [TAP_W-1:0]       tap;
  logic [TAP_W-1:0]       q_tap;
  logic                   q_valid;
  logic [RW-1:0]          scan_row;
  logic [CW-1:0]          scan_col;
  logic [DIM_W-1:0]       frame_rows;
  logic [DIM_W-1:0]       frame_cols;
  logic signed [IN_W-1:0] fill_marker;

  logic                   req_accept;
  logic                   req_inside;
  logic                   run_start;
  logic [AW-1:0]          req_addr;
  logic [AW-1:0]          ctr_addr;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [PIX_W-1:0]       wr_data;
  logic                   wr_en;
  logic [PIX_W-1:0]       rd_data;
  logic [RLIM_W-1:0]      rows_lim;
  logic [CLIM_W-1:0]      cols_lim;
  logic                   frame_small;
  logic                   row_end;
  logic                   last_row;
  pix_t                   fill_fix;
  nbr_ctl_t               nbr_ctl;
  nbr_res_t               nbr_res;

  assign req_stall  = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign req_accept = req_valid && !req_stall;
  assign req_inside = (32'(req_word.row_index) < MAX_ROWS) &&
                      (32'(req_word.col_index) < MAX_COLS);
  assign run_start  = req_accept && (req_word.cmd == CMD_RUN) && !frame_small;
  assign req_addr   = AW'(32'(req_word.row_index) * MAX_COLS + 32'(req_word.col_index));
  assign ctr_addr   = AW'(32'(scan_row) * MAX_COLS + 32'(scan_col));

  assign rows_lim = (RLIM_W'(frame_rows) > RLIM_W'(MAX_ROWS)) ? RLIM_W'(MAX_ROWS)
                                                               : RLIM_W'(frame_rows);
  assign cols_lim = (CLIM_W'(frame_cols) > CLIM_W'(MAX_COLS)) ? CLIM_W'(MAX_COLS)
                                                               : CLIM_W'(frame_cols);
  assign frame_small = (rows_lim < RLIM_W'(3)) || (cols_lim < CLIM_W'(3));
  assign row_end     = (CLIM_W'(scan_col) + CLIM_W'(2)) >= cols_lim;
  assign last_row    = (RLIM_W'(scan_row) + RLIM_W'(2)) >= rows_lim;

  assign fill_fix = to_fixed(fill_marker, FRAC_BITS);

  always_comb begin
    if (state == S_FETCH) begin
      case (tap)
        4'd1:    rd_addr = ctr_addr - A_COLS - A_ONE;
        4'd2:    rd_addr = ctr_addr - A_COLS;
        4'd3:    rd_addr = ctr_addr - A_COLS + A_ONE;
        4'd4:    rd_addr = ctr_addr - A_ONE;
        4'd5:    rd_addr = ctr_addr + A_ONE;
        4'd6:    rd_addr = ctr_addr + A_COLS - A_ONE;
        4'd7:    rd_addr = ctr_addr + A_COLS;
        4'd8:    rd_addr = ctr_addr + A_COLS + A_ONE;
        default: rd_addr = ctr_addr;
      endcase
    end else begin
      rd_addr = req_addr;
    end
  end

  always_comb begin
    if (state == S_WB) begin
      wr_en   = nbr_res.update;
      wr_addr = ctr_addr;
      wr_data = nbr_res.value;
    end else begin
      wr_en   = req_accept && (req_word.cmd == CMD_WRITE) && req_inside;
      wr_addr = req_addr;
      wr_data = to_fixed(req_word.pixel_in, FRAC_BITS);
    end
  end

  assign nbr_ctl.take      = q_valid;
  assign nbr_ctl.is_center = (q_tap == TAP_CENTER);

  rpc_frame_mem #(
    .DEPTH (DEPTH),
    .DW    (PIX_W),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpc_nbr_unit u_nbr (
    .clk      (clk),
    .ctl      (nbr_ctl),
    .data     (rd_data),
    .fill_fix (fill_fix),
    .res      (nbr_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows  <= ROWS_RESET;
      frame_cols  <= COLS_RESET;
      fill_marker <= FILL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: frame_rows  <= cfg_data[DIM_W-1:0];
        REG_COLS: frame_cols  <= cfg_data[DIM_W-1:0];
        REG_FILL: fill_marker <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap       <= '0;
      q_tap     <= '0;
      q_valid   <= 1'b0;
      scan_row  <= '0;
      scan_col  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      q_valid <= (state == S_FETCH);
      q_tap   <= tap;
      unique case (state)
        S_IDLE: begin
          if (req_accept) begin
            rsp_word.pixel_out <= '0;
            rsp_word.pass_done <= (req_word.cmd == CMD_RUN);
            unique case (req_word.cmd)
              CMD_READ: begin
                rsp_valid <= !req_inside;
                if (req_inside) begin
                  state <= S_READ;
                end
              end
              CMD_RUN: begin
                rsp_valid <= !run_start;
                if (run_start) begin
                  scan_row <= RW'(1);
                  scan_col <= CW'(1);
                  tap      <= TAP_CENTER;
                  state    <= S_FETCH;
                end
              end
              default: rsp_valid <= 1'b1;
            endcase
          end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
          end
        end
        S_READ: begin
          rsp_valid          <= 1'b1;
          rsp_word.pixel_out <= rd_data;
          rsp_word.pass_done <= 1'b0;
          state              <= S_IDLE;
        end
        S_FETCH: begin
          if (tap == TAP_LAST) begin
            state <= S_DRAIN;
          end else begin
            tap <= tap + TAP_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_WB;
        end
        S_WB: begin
          tap <= TAP_CENTER;
          if (!row_end) begin
            scan_col <= scan_col + CW'(1);
            state    <= S_FETCH;
          end else if (!last_row) begin
            scan_row <= scan_row + RW'(1);
            scan_col <= CW'(1);
            state    <= S_FETCH;
          end else begin
            scan_row           <= '0;
            scan_col           <= '0;
            rsp_valid          <= 1'b1;
            rsp_word.pixel_out <= '0;
            rsp_word.pass_done <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RPC_ASSERT(a_busy_no_result, clk, rst, (state == S_IDLE) || !rsp_valid)
  `RPC_ASSERT(a_drain_last_tap, clk, rst, (state != S_DRAIN) || (q_valid && (q_tap == TAP_LAST)))
  `RPC_ASSERT(a_scan_interior, clk, rst, (state != S_FETCH) || ((scan_row != '0) && (scan_col != '0)))
  `RPC_ASSERT_NEXT(a_run_starts, clk, rst, run_start, (state == S_FETCH) && (tap == TAP_CENTER))

endmodule

`default_nettype wire

// ===== tb/tb_raster_isolated_point_cleanup.sv =====
`timescale 1ns / 1ps
// Self-checking testbench that predicts and checks every response word of the pixel cleanup block.
module tb_raster_isolated_point_cleanup;
  import rpc_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_DIM      = 256;
  localparam int FRAC         = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int PRINT_CAP    = 100;

  localparam logic [1:0]           CMD_NONE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  in_word_t             req_word  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  out_word_t            rsp_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  pix_t              frame_mem [0:MAX_DIM*MAX_DIM-1];
  bit                written   [0:MAX_DIM*MAX_DIM-1];
  int                written_list [$];
  out_word_t         expected_q [$];
  out_word_t         check_want;
  logic [DIM_W-1:0]  cfg_rows = ROWS_RESET;
  logic [DIM_W-1:0]  cfg_cols = COLS_RESET;
  logic signed [15:0] cfg_fill = FILL_RESET;

  int errors       = 0;
  int results_seen = 0;
  int active_words = 0;
  int passes_run   = 0;
  int burst_left   = 0;
  bit steady       = 1'b0;
  int stall_left   = 0;
  int stall_mode   = 0;
  int stall_tick   = 0;

  raster_isolated_point_cleanup DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic pix_t fixed_of(logic signed [15:0] v);
    return pix_t'({v, {FRAC{1'b0}}});
  endfunction

  function automatic bit is_missing(pix_t v, pix_t fillv);
    return (v == 0) || (v == fillv);
  endfunction

  function automatic void clean_frame();
    int rows, cols, bad, good, sum, at;
    pix_t fillv, ctr, v;
    rows = (int'(cfg_rows) > MAX_DIM) ? MAX_DIM : int'(cfg_rows);
    cols = (int'(cfg_cols) > MAX_DIM) ? MAX_DIM : int'(cfg_cols);
    fillv = fixed_of(cfg_fill);
    if (rows < 3 || cols < 3) return;
    for (int r = 1; r < rows - 1; r++) begin
      for (int c = 1; c < cols - 1; c++) begin
        at = r * MAX_DIM + c;
        ctr = frame_mem[at];
        bad = 0;
        good = 0;
        sum = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              v = frame_mem[(r + dr) * MAX_DIM + c + dc];
              if (is_missing(v, fillv)) begin
                bad++;
              end else begin
                good++;
                sum += int'(v);
              end
            end
          end
        end
        if (!is_missing(ctr, fillv)) begin
          if (bad >= DEL_LIMIT) frame_mem[at] = '0;
        end else if (good == NBR_COUNT) begin
          frame_mem[at] = pix_t'(sum / NBR_COUNT);
        end
      end
    end
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t res;
    int at;
    res = '0;
    at = int'({w.row_index, w.col_index});
    case (w.cmd)
      CMD_WRITE: begin
        frame_mem[at] = fixed_of(w.pixel_in);
        if (!written[at]) begin
          written[at] = 1'b1;
          written_list.insert(written_list.size(), at);
        end
      end
      CMD_RUN: begin
        clean_frame();
        passes_run++;
        res.pass_done = 1'b1;
      end
      CMD_READ: res.pixel_out = frame_mem[at];
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic signed [15:0] pick_pixel(int miss_pct);
    if ($urandom_range(0, 99) < miss_pct) return ($urandom_range(0, 1) != 0) ? 16'sd0 : cfg_fill;
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom_range(0, 16) - 8);
      2:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      3:       return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP) $display("ERROR at %0t: %s got %h, want %h", $time, what, got, want);
  endtask

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!steady) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (w.cmd != CMD_NONE) active_words++;
    expected_q.insert(expected_q.size(), predict_word(w));
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] r, input logic [7:0] c,
                          input logic signed [15:0] v);
    in_word_t w;
    w.cmd       = cmd;
    w.row_index = r;
    w.col_index = c;
    w.pixel_in  = v;
    send_word(w);
  endtask

  task automatic send_noise();
    int at;
    case ($urandom_range(0, 2))
      0: send_cmd(CMD_WRITE, 8'($urandom), 8'($urandom), 16'($urandom));
      1: begin
        at = written_list[$urandom_range(0, written_list.size() - 1)];
        send_cmd(CMD_READ, at[15:8], at[7:0], 16'($urandom));
      end
      default: send_cmd(CMD_NONE, 8'($urandom), 8'($urandom), 16'($urandom));
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROWS: cfg_rows = val[DIM_W-1:0];
      REG_COLS: cfg_cols = val[DIM_W-1:0];
      REG_FILL: cfg_fill = val;
      default: ;
    endcase
  endtask

  task automatic test_word_types();
    send_cmd(CMD_WRITE, 8'd0, 8'd0, 16'sh7fff);
    send_cmd(CMD_WRITE, 8'd255, 8'd255, 16'sh8000);
    send_cmd(CMD_WRITE, 8'd0, 8'd255, 16'sd0);
    send_cmd(CMD_WRITE, 8'd255, 8'd0, -16'sd1);
    send_cmd(CMD_READ, 8'd0, 8'd0, 16'sd0);
    send_cmd(CMD_READ, 8'd255, 8'd255, 16'sh7fff);
    send_cmd(CMD_READ, 8'd0, 8'd255, 16'sd0);
    send_cmd(CMD_READ, 8'd255, 8'd0, 16'sd0);
    send_cmd(CMD_NONE, 8'hff, 8'hff, 16'shffff);
    send_cmd(CMD_READ, 8'd0, 8'd0, 16'sd0);
  endtask

  task automatic test_no_interior();
    wait_idle();
    write_reg(REG_ROWS, 16'd1);
    write_reg(REG_COLS, 16'd1);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    wait_idle();
    write_reg(REG_ROWS, 16'd2);
    write_reg(REG_COLS, 16'd256);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    wait_idle();
    write_reg(REG_ROWS, 16'd256);
    write_reg(REG_COLS, 16'd2);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    wait_idle();
    write_reg(REG_ROWS, 16'd0);
    write_reg(REG_COLS, 16'd0);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    send_cmd(CMD_READ, 8'd255, 8'd255, 16'sd0);
  endtask

  task automatic test_isolated_point();
    logic signed [15:0] vals [9];
    vals = '{16'sd0, 16'sd123, 16'sd0, 16'sd123, 16'sd500, 16'sd7, 16'sd0, -16'sd7, 16'sh7fff};
    wait_idle();
    write_reg(REG_ROWS, 16'd3);
    write_reg(REG_COLS, 16'd3);
    write_reg(REG_FILL, 16'd123);
    for (int i = 0; i < 9; i++) send_cmd(CMD_WRITE, 8'(i / 3), 8'(i % 3), vals[i]);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    send_cmd(CMD_READ, 8'd1, 8'd1, 16'sd0);
    send_cmd(CMD_WRITE, 8'd1, 8'd2, 16'sd123);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    send_cmd(CMD_READ, 8'd1, 8'd1, 16'sd0);
    send_cmd(CMD_READ, 8'd0, 8'd2, 16'sd0);
  endtask

  // Each pass fills one missing pixel from a neighbor filled in the pass before, so the
  // fraction bits deepen until the negative mean has to be truncated toward zero.
  task automatic test_mean_chain();
    logic signed [15:0] v;
    wait_idle();
    write_reg(REG_ROWS, 16'd3);
    write_reg(REG_COLS, 16'd5);
    write_reg(REG_FILL, FILL_RESET);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 5; c++) begin
        v = -16'sd1;
        if (r == 0 && c == 0) v = -16'sd2;
        if (r == 1 && c == 1) v = 16'sd0;
        send_cmd(CMD_WRITE, 8'(r), 8'(c), v);
      end
    end
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    send_cmd(CMD_WRITE, 8'd1, 8'd2, FILL_RESET);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    send_cmd(CMD_WRITE, 8'd1, 8'd3, 16'sd0);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    for (int c = 1; c < 4; c++) send_cmd(CMD_READ, 8'd1, 8'(c), 16'sd0);
  endtask

  task automatic test_saturated_size();
    wait_idle();
    write_reg(REG_ROWS, 16'd256);
    write_reg(REG_COLS, 16'd3);
    write_reg(REG_FILL, FILL_RESET);
    for (int r = 0; r < MAX_DIM; r++)
      for (int c = 0; c < 3; c++) send_cmd(CMD_WRITE, 8'(r), 8'(c), pick_pixel(25));
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    wait_idle();
    write_reg(REG_ROWS, 16'd511);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
    repeat (8) send_cmd(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 2)), 16'sd0);
    wait_idle();
    write_reg(REG_ROWS, 16'd2);
    write_reg(REG_COLS, 16'd300);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'sd0);
  endtask

  task automatic test_random_frames();
    int rows, cols, rr, cc, miss_pct, stop_at;
    bit framed;
    logic signed [15:0] fill;
    stop_at = active_words + RANDOM_ITEMS;
    while (active_words < stop_at) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: begin
          rows = $urandom_range(0, 2);
          cols = $urandom_range(0, 511);
        end
        1: begin
          rows = $urandom_range(0, 511);
          cols = $urandom_range(0, 2);
        end
        2: begin
          rows = $urandom_range(9, 12);
          cols = $urandom_range(3, 12);
        end
        default: begin
          rows = $urandom_range(3, 8);
          cols = $urandom_range(3, 8);
        end
      endcase
      case ($urandom_range(0, 5))
        0: fill = FILL_RESET;
        1: fill = 16'sh8000;
        2: fill = 16'sh7fff;
        3: fill = 16'sd0;
        4: fill = 16'($urandom);
        default: fill = 16'($urandom_range(0, 8) - 4);
      endcase
      write_reg(REG_ROWS, 16'(rows));
      write_reg(REG_COLS, 16'(cols));
      if ($urandom_range(0, 3) != 0) write_reg(REG_FILL, fill);
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, 16'($urandom));
      steady = ($urandom_range(0, 3) == 0);
      miss_pct = $urandom_range(0, 80);
      rr = (rows > MAX_DIM) ? MAX_DIM : rows;
      cc = (cols > MAX_DIM) ? MAX_DIM : cols;
      framed = (rr >= 3) && (cc >= 3);
      if (framed) begin
        for (int r = 0; r < rr; r++) begin
          for (int c = 0; c < cc; c++) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            send_cmd(CMD_WRITE, 8'(r), 8'(c), pick_pixel(miss_pct));
          end
        end
      end else begin
        repeat ($urandom_range(4, 12)) send_noise();
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) wait_idle();
        send_cmd(CMD_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 3)) begin
          if (framed) send_cmd(CMD_READ, 8'($urandom_range(0, rr - 1)),
                               8'($urandom_range(0, cc - 1)), 16'($urandom));
          else send_noise();
        end
        if (framed) begin
          repeat ($urandom_range(0, 2))
            send_cmd(CMD_WRITE, 8'($urandom_range(1, rr - 2)), 8'($urandom_range(1, cc - 2)),
                     pick_pixel(miss_pct));
        end
      end
      if (framed) begin
        for (int r = 0; r < rr; r++)
          for (int c = 0; c < cc; c++)
            if ($urandom_range(0, 1) != 0) send_cmd(CMD_READ, 8'(r), 8'(c), 16'($urandom));
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 2) == 0);
      2: rsp_stall <= (stall_tick % 4 != 0);
      default: rsp_stall <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("response word with nothing expected", 32'(rsp_word), '0);
      end else begin
        check_want = expected_q.pop_front();
        if (rsp_word.pixel_out !== check_want.pixel_out)
          report_mismatch("pixel_out", 32'(rsp_word.pixel_out), 32'(check_want.pixel_out));
        if (rsp_word.pass_done !== check_want.pass_done)
          report_mismatch("pass_done", 32'(rsp_word.pass_done), 32'(check_want.pass_done));
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d response words outstanding", expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int guard;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_word_types();
    test_no_interior();
    test_isolated_point();
    test_mean_chain();
    test_saturated_size();
    test_random_frames();
    @(negedge clk);
    req_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (30) @(negedge clk);
    if (expected_q.size() != 0)
      report_mismatch("response words never arrived", 32'(expected_q.size()), '0);
    $display("Checked %0d response words for %0d request words, including %0d cleanup passes.",
             results_seen, active_words, passes_run);
    $display("Frames ranged from empty to saturated sizes with fill markers across the range.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
